// ===== sv/binary_block_framer_crc16_macros.svh =====
// Assertion helpers used by the checker file (bff_checker.sv).
`ifndef BINARY_BLOCK_FRAMER_CRC16_MACROS_SVH
`define BINARY_BLOCK_FRAMER_CRC16_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BFF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define BFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bff_pkg.sv =====
package bff_pkg;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_BLOCK = 2'd2
  } phase_t;

  typedef enum logic {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_index_t;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h24;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h40;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] MIN_LEN         = 16'd8;

  // Byte offsets inside a block (sync pair sits at 0 and 1)
  localparam logic [15:0] OFF_CHK_LO  = 16'd2;
  localparam logic [15:0] OFF_CHK_HI  = 16'd3;
  localparam logic [15:0] OFF_ID_LO   = 16'd4;
  localparam logic [15:0] OFF_ID_HI   = 16'd5;
  localparam logic [15:0] OFF_LEN_LO  = 16'd6;
  localparam logic [15:0] OFF_LEN_HI  = 16'd7;
  localparam logic [15:0] OFF_TOW_0   = 16'd8;
  localparam logic [15:0] OFF_TOW_1   = 16'd9;
  localparam logic [15:0] OFF_TOW_2   = 16'd10;
  localparam logic [15:0] OFF_TOW_3   = 16'd11;
  localparam logic [15:0] OFF_WEEK_LO = 16'd12;
  localparam logic [15:0] OFF_WEEK_HI = 16'd13;
  localparam logic [15:0] CRC_START   = 16'd4;
  localparam logic [15:0] PAY_START   = 16'd14;

  typedef struct packed {
    logic       we;
    cfg_index_t index;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        block_end;
    logic        crc_ok;
    logic [12:0] block_number;
    logic [2:0]  revision;
    logic [15:0] block_length;
    logic [31:0] time_of_week_ms;
    logic [15:0] week_number;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/bff_byte_if.sv =====
interface bff_byte_if import bff_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/bff_result_if.sv =====
interface bff_result_if import bff_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        block_end;
  logic        crc_ok;
  logic [12:0] block_number;
  logic [2:0]  revision;
  logic [15:0] block_length;
  logic [31:0] time_of_week_ms;
  logic [15:0] week_number;

  modport source (
    output valid, output payload_byte, output payload_valid, output block_end,
    output crc_ok, output block_number, output revision, output block_length,
    output time_of_week_ms, output week_number, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input block_end,
    input crc_ok, input block_number, input revision, input block_length,
    input time_of_week_ms, input week_number, output ready
  );
endinterface

// ===== sv/bff_in_reg.sv =====
module bff_in_reg import bff_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== sv/bff_parser.sv =====
module bff_parser import bff_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       step,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  phase_t      phase, phase_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] stored_chk, stored_chk_next;
  logic [15:0] id_rev, id_rev_next;
  logic [15:0] length_held, length_held_next;
  logic [31:0] tow_held, tow_held_next;
  logic [15:0] week_held, week_held_next;

  logic bad_len;
  logic pay;
  logic end_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      phase       <= PH_HUNT1;
      byte_offset <= '0;
      crc_acc     <= '0;
      stored_chk  <= '0;
      id_rev      <= '0;
      length_held <= '0;
      tow_held    <= '0;
      week_held   <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          CFG_SYNC_FIRST:  sync_first  <= cfg.data;
          CFG_SYNC_SECOND: sync_second <= cfg.data;
          default: ;
        endcase
      end
      if (step) begin
        phase       <= phase_next;
        byte_offset <= byte_offset_next;
        crc_acc     <= crc_acc_next;
        stored_chk  <= stored_chk_next;
        id_rev      <= id_rev_next;
        length_held <= length_held_next;
        tow_held    <= tow_held_next;
        week_held   <= week_held_next;
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_offset_next = byte_offset;
    crc_acc_next     = crc_acc;
    stored_chk_next  = stored_chk;
    id_rev_next      = id_rev;
    length_held_next = length_held;
    tow_held_next    = tow_held;
    week_held_next   = week_held;
    bad_len          = 1'b0;
    pay              = 1'b0;
    end_blk          = 1'b0;
    res_valid        = 1'b0;
    res              = '0;

    case (phase)
      PH_HUNT2: begin
        if (in_byte == sync_second) begin
          phase_next       = PH_BLOCK;
          byte_offset_next = OFF_CHK_LO;
          crc_acc_next     = '0;
          stored_chk_next  = '0;
          id_rev_next      = '0;
          length_held_next = '0;
          tow_held_next    = '0;
          week_held_next   = '0;
        end else if (in_byte != sync_first) begin
          phase_next = PH_HUNT1;
        end
      end
      PH_BLOCK: begin
        if (byte_offset >= CRC_START) begin
          crc_acc_next = crc16_byte(crc_acc, in_byte);
        end
        case (byte_offset)
          OFF_CHK_LO:  stored_chk_next  = {stored_chk[15:8], in_byte};
          OFF_CHK_HI:  stored_chk_next  = {in_byte, stored_chk[7:0]};
          OFF_ID_LO:   id_rev_next      = {id_rev[15:8], in_byte};
          OFF_ID_HI:   id_rev_next      = {in_byte, id_rev[7:0]};
          OFF_LEN_LO:  length_held_next = {length_held[15:8], in_byte};
          OFF_LEN_HI:  length_held_next = {in_byte, length_held[7:0]};
          OFF_TOW_0, OFF_TOW_1, OFF_TOW_2, OFF_TOW_3:
            tow_held_next = tow_held | ({24'd0, in_byte} << {byte_offset[1:0], 3'b000});
          OFF_WEEK_LO: week_held_next   = week_held | {8'd0, in_byte};
          OFF_WEEK_HI: week_held_next   = week_held | {in_byte, 8'd0};
          default: ;
        endcase

        bad_len = (byte_offset == OFF_LEN_HI) &&
                  ((length_held_next < MIN_LEN) || (length_held_next[1:0] != 2'b00));

        if (bad_len) begin
          phase_next       = PH_HUNT1;
          byte_offset_next = '0;
        end else begin
          pay     = byte_offset >= PAY_START;
          end_blk = (byte_offset >= OFF_LEN_HI) &&
                    (({1'b0, byte_offset} + 17'd1) >= {1'b0, length_held_next});
          if (end_blk) begin
            phase_next       = PH_HUNT1;
            byte_offset_next = '0;
          end else begin
            byte_offset_next = byte_offset + 16'd1;
          end
        end

        res_valid = pay || end_blk;
        if (pay) begin
          res.payload_byte  = in_byte;
          res.payload_valid = 1'b1;
        end
        if (end_blk) begin
          res.block_end       = 1'b1;
          res.crc_ok          = crc_acc_next == stored_chk_next;
          res.block_number    = id_rev_next[12:0];
          res.revision        = id_rev_next[15:13];
          res.block_length    = length_held_next;
          res.time_of_week_ms = tow_held_next;
          res.week_number     = week_held_next;
        end
      end
      default: begin
        // hunting; the unused code behaves the same
        phase_next = (in_byte == sync_first) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

endmodule

// ===== sv/bff_out_reg.sv =====
module bff_out_reg import bff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t d,
  output logic    can_take,
  output logic    valid,
  output result_t q,
  input  logic    ready
);

  assign can_take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      q <= d;
    end
  end

endmodule

// ===== sv/binary_block_framer_crc16.sv =====
// Channel  Dir  Payload                                      Transaction when
// rx       in   in_byte (8)                                  rx.valid & rx.ready
// res      out  payload byte/flag, block summary, crc_ok     res.valid & res.ready
//
// One byte per cycle sustained while res keeps up. Each byte is registered in
// the input register, then the CRC step and header capture run into the result
// register once it can take a new entry. Bytes that give no result still pass
// through the same slot. rx stalls only while the result register holds a
// transaction that res has not taken. Reset (rst, synchronous) empties both
// registers, returns to sync hunting and restores the sync bytes.
module binary_block_framer_crc16 import bff_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  cfg_index_t    cfg_index,
  input  logic [7:0]    cfg_data,
  bff_byte_if.sink      rx,
  bff_result_if.source  res
);

  cfg_wr_t    cfg;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_take;
  logic       step;
  logic       p_valid;
  result_t    p_res;
  result_t    q;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign step = held_valid && can_take;

  bff_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.in_byte),
    .in_ready   (rx.ready),
    .advance    (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  bff_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .in_byte   (held_byte),
    .res_valid (p_valid),
    .res       (p_res)
  );

  bff_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && p_valid),
    .d        (p_res),
    .can_take (can_take),
    .valid    (res.valid),
    .q        (q),
    .ready    (res.ready)
  );

  assign res.payload_byte    = q.payload_byte;
  assign res.payload_valid   = q.payload_valid;
  assign res.block_end       = q.block_end;
  assign res.crc_ok          = q.crc_ok;
  assign res.block_number    = q.block_number;
  assign res.revision        = q.revision;
  assign res.block_length    = q.block_length;
  assign res.time_of_week_ms = q.time_of_week_ms;
  assign res.week_number     = q.week_number;

endmodule

// ===== sv/bff_checker.sv =====
`include "binary_block_framer_crc16_macros.svh"

module bff_checker import bff_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  payload_byte,
  input logic        payload_valid,
  input logic        block_end,
  input logic        crc_ok,
  input logic [12:0] block_number,
  input logic [2:0]  revision,
  input logic [15:0] block_length,
  input logic [31:0] time_of_week_ms,
  input logic [15:0] week_number
);

  // every transaction is a payload byte, a block end or both
  `BFF_ASSERT_NOW(a_res_has_content, clk, rst, res_valid, payload_valid || block_end, "empty result")

  `BFF_ASSERT_NOW(a_no_stray_payload, clk, rst, res_valid && !payload_valid, payload_byte == 8'd0, "payload byte without flag")

  // summary fields only on the final byte
  `BFF_ASSERT_NOW(a_summary_zero, clk, rst, res_valid && !block_end, !crc_ok && (block_number == 13'd0) && (revision == 3'd0) && (block_length == 16'd0) && (time_of_week_ms == 32'd0) && (week_number == 16'd0), "summary outside block end")

  // a block end reports a legal length
  `BFF_ASSERT_NOW(a_end_len_legal, clk, rst, res_valid && block_end, (block_length >= MIN_LEN) && (block_length[1:0] == 2'b00), "block end with bad length")

  `BFF_ASSERT_NEXT(a_hold_stalled, clk, rst, res_valid && !res_ready, res_valid && $stable(payload_byte) && $stable(block_end) && $stable(block_length), "stalled result changed")

endmodule

bind binary_block_framer_crc16 bff_checker u_bff_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .payload_byte    (res.payload_byte),
  .payload_valid   (res.payload_valid),
  .block_end       (res.block_end),
  .crc_ok          (res.crc_ok),
  .block_number    (res.block_number),
  .revision        (res.revision),
  .block_length    (res.block_length),
  .time_of_week_ms (res.time_of_week_ms),
  .week_number     (res.week_number)
);

// ===== tb/tb_binary_block_framer_crc16.sv =====
`timescale 1ns / 100ps

import bff_pkg::*;

class framer_scoreboard;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  phase_t      ph;
  logic [15:0] offset;
  logic [15:0] crc_run;
  logic [15:0] crc_stored;
  logic [15:0] id_rev;
  logic [15:0] len_held;
  logic [31:0] tow;
  logic [15:0] week;
  result_t     expected_q[$];
  int          errors;
  int          bytes_in;
  int          results_seen;
  int          ends_seen;
  int          bad_crc_seen;
  int          drops_seen;

  function new();
    sync_a = SYNC_FIRST_RST;
    sync_b = SYNC_SECOND_RST;
    ph = PH_HUNT1;
    offset = '0;
    crc_run = '0;
    crc_stored = '0;
    id_rev = '0;
    len_held = '0;
    tow = '0;
    week = '0;
    errors = 0;
    bytes_in = 0;
    results_seen = 0;
    ends_seen = 0;
    bad_crc_seen = 0;
    drops_seen = 0;
  endfunction

  // XMODEM step, one bit at a time, MSB first
  static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function void set_sync(logic [7:0] a, logic [7:0] b);
    sync_a = a;
    sync_b = b;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_byte(logic [7:0] b);
    logic [15:0] off;
    logic        pay;
    logic        fin;
    result_t     r;
    bytes_in++;
    case (ph)
      PH_HUNT2: begin
        // second sync is checked first, so equal sync values start a block here
        if (b == sync_b) begin
          ph = PH_BLOCK;
          offset = OFF_CHK_LO;
          crc_run = '0;
          crc_stored = '0;
          id_rev = '0;
          len_held = '0;
          tow = '0;
          week = '0;
        end else if (b != sync_a) begin
          ph = PH_HUNT1;
        end
      end
      PH_BLOCK: begin
        off = offset;
        if (off >= CRC_START) crc_run = crc_next(crc_run, b);
        case (off)
          OFF_CHK_LO:  crc_stored[7:0] = b;
          OFF_CHK_HI:  crc_stored[15:8] = b;
          OFF_ID_LO:   id_rev[7:0] = b;
          OFF_ID_HI:   id_rev[15:8] = b;
          OFF_LEN_LO:  len_held[7:0] = b;
          OFF_LEN_HI:  len_held[15:8] = b;
          OFF_TOW_0:   tow[7:0] = b;
          OFF_TOW_1:   tow[15:8] = b;
          OFF_TOW_2:   tow[23:16] = b;
          OFF_TOW_3:   tow[31:24] = b;
          OFF_WEEK_LO: week[7:0] = b;
          OFF_WEEK_HI: week[15:8] = b;
          default: ;
        endcase
        if (off == OFF_LEN_HI && (len_held < MIN_LEN || len_held[1:0] != 2'b00)) begin
          ph = PH_HUNT1;
          offset = '0;
          drops_seen++;
          return;
        end
        pay = (off >= PAY_START);
        fin = (off >= OFF_LEN_HI) && (({1'b0, off} + 17'd1) >= {1'b0, len_held});
        if (fin) begin
          ph = PH_HUNT1;
          offset = '0;
        end else begin
          offset = off + 16'd1;
        end
        if (pay || fin) begin
          r = '0;
          if (pay) begin
            r.payload_byte = b;
            r.payload_valid = 1'b1;
          end
          if (fin) begin
            r.block_end = 1'b1;
            r.crc_ok = (crc_run == crc_stored);
            r.block_number = id_rev[12:0];
            r.revision = id_rev[15:13];
            r.block_length = len_held;
            r.time_of_week_ms = tow;
            r.week_number = week;
            ends_seen++;
            if (crc_run != crc_stored) bad_crc_seen++;
          end
          expected_q = {expected_q, r};
        end
      end
      default: ph = (b == sync_a) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h, expected %0h",
                       results_seen, name, got, want));
  endtask

  task check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_seen));
      results_seen++;
      return;
    end
    want = expected_q.pop_front();
    check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    check_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
    check_field("block_end", 32'(got.block_end), 32'(want.block_end));
    check_field("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
    check_field("block_number", 32'(got.block_number), 32'(want.block_number));
    check_field("revision", 32'(got.revision), 32'(want.revision));
    check_field("block_length", 32'(got.block_length), 32'(want.block_length));
    check_field("time_of_week_ms", got.time_of_week_ms, want.time_of_week_ms);
    check_field("week_number", 32'(got.week_number), 32'(want.week_number));
    results_seen++;
  endtask
endclass

module tb_binary_block_framer_crc16;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 200;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_data;

  bff_byte_if   rx_if();
  bff_result_if res_if();

  binary_block_framer_crc16 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_if),
    .res       (res_if)
  );

  framer_scoreboard sb;
  int         cycles = 0;
  int         burst_left = 0;
  logic [7:0] cur_sf = SYNC_FIRST_RST;
  logic [7:0] cur_ss = SYNC_SECOND_RST;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: segments of always-ready and of periodic stall patterns, picked at random
  initial begin
    int seg_left;
    int period;
    int duty;
    int cnt;
    bit steady;
    seg_left = 0;
    period = 1;
    duty = 1;
    cnt = 0;
    steady = 1'b1;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(300, 64);
        steady = ($urandom_range(2) == 0);
        period = $urandom_range(9, 2);
        duty = $urandom_range(period - 1, 1);
      end
      seg_left--;
      cnt++;
      res_if.ready <= steady ? 1'b1 : ((cnt % period) < duty);
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("simulation failed");
      $finish;
    end
    if (!rst && rx_if.valid && rx_if.ready) sb.note_byte(rx_if.in_byte);
    if (!rst && res_if.valid && res_if.ready) begin
      got.payload_byte    = res_if.payload_byte;
      got.payload_valid   = res_if.payload_valid;
      got.block_end       = res_if.block_end;
      got.crc_ok          = res_if.crc_ok;
      got.block_number    = res_if.block_number;
      got.revision        = res_if.revision;
      got.block_length    = res_if.block_length;
      got.time_of_week_ms = res_if.time_of_week_ms;
      got.week_number     = res_if.week_number;
      sb.check_result(got);
    end
  end

  // sender works in bursts; a gap drops valid before the next burst
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx_if.valid <= 1'b1;
    rx_if.in_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // one framed block; a bad length field sends the header only
  task automatic send_block(input logic [15:0] len_field, input logic [15:0] id,
                            input fill_t fill, input bit corrupt);
    logic [7:0]  blk[$];
    logic [15:0] crc;
    int          n;
    n = (len_field < MIN_LEN || len_field[1:0] != 2'b00) ? 8 : int'(len_field);
    blk = {blk, cur_sf};
    blk = {blk, cur_ss};
    blk = {blk, 8'h00};
    blk = {blk, 8'h00};
    blk = {blk, id[7:0]};
    blk = {blk, id[15:8]};
    blk = {blk, len_field[7:0]};
    blk = {blk, len_field[15:8]};
    for (int i = 8; i < n; i++) begin
      case (fill)
        FILL_ZERO: blk = {blk, 8'h00};
        FILL_ONES: blk = {blk, 8'hFF};
        default:   blk = {blk, 8'($urandom)};
      endcase
    end
    crc = '0;
    for (int i = 4; i < n; i++) crc = sb.crc_next(crc, blk[i]);
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(15, 0));
    blk[2] = crc[7:0];
    blk[3] = crc[15:8];
    foreach (blk[i]) send_byte(blk[i]);
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    // let the monitor note the last accepted byte first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // bytes that make no result may still be in the pipe
    repeat (6) @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] a, input logic [7:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sf = a;
    cur_ss = b;
    sb.set_sync(a, b);
  endtask

  function automatic logic [7:0] pick_noise(input bit avoid_second);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == cur_sf || (avoid_second && v == cur_ss)) v = 8'($urandom);
    return v;
  endfunction

  task automatic run_random(input int budget);
    int         sent;
    int         pick;
    int         len;
    int         extra;
    logic [15:0] lf;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? 4 * $urandom_range(64, 17)
                                      : 4 * $urandom_range(12, 2);
      if (pick < 55) begin
        send_block(16'(len), 16'($urandom), FILL_RANDOM, $urandom_range(4) == 0);
        sent += len;
      end else if (pick < 65) begin
        lf = 16'($urandom);
        if ($urandom_range(1) == 0) lf = 16'($urandom_range(7));
        else if (lf[1:0] == 2'b00) lf[0] = 1'b1;
        send_block(lf, 16'($urandom), FILL_RANDOM, 1'b0);
        sent += 8;
      end else if (pick < 75) begin
        // extra first-sync bytes ahead of a block
        extra = (cur_sf != cur_ss) ? $urandom_range(3, 1) : 0;
        repeat (extra) send_byte(cur_sf);
        send_block(16'(len), 16'($urandom), FILL_RANDOM, $urandom_range(4) == 0);
        sent += extra + len;
      end else if (pick < 85) begin
        send_byte(cur_sf);
        send_byte(pick_noise(1'b1));
        sent += 2;
      end else begin
        extra = $urandom_range(6, 1);
        repeat (extra) send_byte(pick_noise(1'b0));
        sent += extra;
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SYNC_FIRST;
    cfg_data = 8'h00;
    rx_if.valid = 1'b0;
    rx_if.in_byte = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // repeated first sync, then full-ones id and content
    send_byte(cur_sf);
    send_block(16'd12, 16'hFFFF, FILL_ONES, 1'b0);
    // header dropped on a short odd length
    send_block(16'd7, 16'h1234, FILL_ZERO, 1'b0);
    // minimal block with no time fields and a bad checksum
    send_block(16'd8, 16'h0000, FILL_ZERO, 1'b1);

    run_random(RANDOM_BYTES);
    set_sync(8'h00, 8'hFF);
    run_random(RANDOM_BYTES);
    set_sync(8'hFF, 8'h00);
    run_random(RANDOM_BYTES);
    set_sync(8'hA5, 8'hA5);
    run_random(RANDOM_BYTES);
    set_sync(8'($urandom), 8'($urandom));
    run_random(RANDOM_BYTES);

    drain();
    if (sb.pending() != 0) sb.report("expected results left over at end");
    $display("%0d bytes sent over 5 sync settings; %0d results checked", sb.bytes_in,
             sb.results_seen);
    $display("%0d blocks closed (%0d with checksum mismatch), %0d headers dropped",
             sb.ends_seen, sb.bad_crc_seen, sb.drops_seen);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
